FILE: hdl/palette_blend_nearest_color_defines.svh
// Assertion macros for the palette blend and nearest colour block.
// No dependencies; included by the checker only.
`ifndef PALETTE_BLEND_NEAREST_COLOR_DEFINES_SVH
`define PALETTE_BLEND_NEAREST_COLOR_DEFINES_SVH

// Consequent checked in the clock after the antecedent.
`define PBNC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pbnc: property violated");

// Consequent checked in the same clock as the antecedent.
`define PBNC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pbnc: property violated");

`endif

FILE: hdl/pbnc_pkg.sv
// Shared types, widths and codes for the palette blend and nearest colour block.
// No dependencies; imported by every other file but pbnc_ram and the defines header.
package pbnc_pkg;

    localparam int COLOR_W    = 8;
    localparam int LEVEL_W    = 6;
    localparam int IDX_W      = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int STRENGTH_W = 9;
    localparam int LS_W       = 16;   // level * strength, at most 255 * 256
    localparam int MIX_W      = 24;   // p*(D-LS) + s*LS, at most 255 * D
    localparam int NUM_W      = 25;   // 2*mix + D
    localparam int DIST_W     = 18;   // sum of three squared differences

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int SHADE_LEVELS_DEF    = 64;

    localparam logic [STRENGTH_W-1:0] STRENGTH_ONE = 9'd256;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE     = 2'd3;

    localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 9'd102;
    localparam logic [COLOR_W-1:0]    RED_RST      = 8'd204;
    localparam logic [COLOR_W-1:0]    GREEN_RST    = 8'd230;
    localparam logic [COLOR_W-1:0]    BLUE_RST     = 8'd255;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    // One channel handed to the blend unit
    typedef struct packed {
        logic               vld;
        logic [COLOR_W-1:0] base;
        logic [COLOR_W-1:0] sheen;
    } mix_req_t;

    // Tag that travels with each palette read of the scan
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] index;
    } scan_tag_t;

endpackage

FILE: hdl/pbnc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pbnc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/pbnc_blend.sv
// Two-stage blend unit: one colour channel in per cycle, blended channel out of the second stage.
// Depends on pbnc_pkg.
module pbnc_blend #(
    parameter int SHADE_LEVELS = pbnc_pkg::SHADE_LEVELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pbnc_pkg::mix_req_t           req,
    input  logic [pbnc_pkg::LS_W-1:0]    ls,
    output logic                         res_vld,
    output logic [pbnc_pkg::COLOR_W-1:0] res
);
    import pbnc_pkg::*;

    // Divide by 2*D through a reciprocal: SH is chosen so that the
    // truncation error stays below one step for every numerator.
    localparam longint unsigned DIV   = longint'(SHADE_LEVELS - 1) * 256;
    localparam int              SH    = $clog2(64'd1024 * DIV * DIV);
    localparam longint unsigned RECIP = ((64'd1 << SH) + 2 * DIV - 1) / (2 * DIV);
    localparam int              RW    = $clog2(RECIP + 1);
    localparam int              PROD_W = NUM_W + RW;

    logic [LS_W-1:0]    d_minus_ls;
    logic [MIX_W-1:0]   mix_next;
    logic [MIX_W-1:0]   mix_reg;
    logic               s1_vld_reg;
    logic [NUM_W-1:0]   num;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  shifted;
    logic               res_vld_reg;
    logic [COLOR_W-1:0] res_reg;

    assign d_minus_ls = LS_W'(DIV) - ls;
    assign mix_next   = MIX_W'(req.base * d_minus_ls) + MIX_W'(req.sheen * ls);

    assign num     = {mix_reg, 1'b0} + NUM_W'(DIV);
    assign prod    = PROD_W'(num) * PROD_W'(RECIP);
    assign shifted = prod >> SH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= req.vld;
            res_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
        res_reg <= shifted[COLOR_W-1:0];
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

FILE: hdl/pbnc_search.sv
// Nearest-colour search unit: one palette entry per cycle, squared distance, running minimum.
// Depends on pbnc_pkg.
module pbnc_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pbnc_pkg::scan_tag_t        ent_tag,
    input  pbnc_pkg::rgb_t             ent_color,
    input  pbnc_pkg::rgb_t             target,
    output logic [pbnc_pkg::IDX_W-1:0] best_index,
    output logic                       done
);
    import pbnc_pkg::*;

    logic signed [COLOR_W:0]     dr;
    logic signed [COLOR_W:0]     dg;
    logic signed [COLOR_W:0]     db;
    logic signed [2*COLOR_W+1:0] sq_r;
    logic signed [2*COLOR_W+1:0] sq_g;
    logic signed [2*COLOR_W+1:0] sq_b;
    logic [DIST_W-1:0]           dist_next;
    logic [DIST_W-1:0]           dist_reg;
    scan_tag_t                   tag_reg;
    logic [DIST_W-1:0]           best_dist_reg;
    logic [IDX_W-1:0]            best_index_reg;
    logic                        done_reg;
    logic                        take;

    assign dr   = $signed({1'b0, ent_color.red})   - $signed({1'b0, target.red});
    assign dg   = $signed({1'b0, ent_color.green}) - $signed({1'b0, target.green});
    assign db   = $signed({1'b0, ent_color.blue})  - $signed({1'b0, target.blue});
    assign sq_r = dr * dr;
    assign sq_g = dg * dg;
    assign sq_b = db * db;
    assign dist_next = DIST_W'($unsigned(sq_r)) + DIST_W'($unsigned(sq_g))
                     + DIST_W'($unsigned(sq_b));

    // Strictly less keeps the lowest index on a tie
    assign take = tag_reg.vld && (tag_reg.first || (dist_reg < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= ent_tag;
            done_reg <= tag_reg.vld && tag_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        if (take)
        begin
            best_dist_reg  <= dist_reg;
            best_index_reg <= tag_reg.index;
        end
    end

    assign best_index = best_index_reg;
    assign done       = done_reg;

endmodule

FILE: hdl/palette_blend_nearest_color.sv
// Palette blend and nearest colour search. A write item stores one RGB entry in
// the palette; a query item blends its base entry toward the sheen colour by
// level/(SHADE_LEVELS-1) * strength/256 and returns the index of the palette
// entry at least squared RGB distance, lowest index on a tie. A write passes
// through the index wrap, then the RAM write, and gives no result. A query
// wraps the index and reads the base entry, sends the three channels through
// the blend unit, scans every palette entry in turn, paced by the single read
// port of the palette RAM, drains the search pipeline and then loads the result
// register once it is free. The next item is taken as soon as the result is
// loaded, even while that result waits to be taken. The palette is not cleared
// after reset, so every entry must be written before the first query. Colour
// indexes at or above PALETTE_ENTRIES wrap around; levels and strength above
// their maxima saturate.
// Depends on pbnc_pkg, pbnc_ram, pbnc_blend and pbnc_search.
module palette_blend_nearest_color #(
    parameter int PALETTE_ENTRIES = pbnc_pkg::PALETTE_ENTRIES_DEF,
    parameter int SHADE_LEVELS    = pbnc_pkg::SHADE_LEVELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pbnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pbnc_pkg::CFG_DATA_W-1:0] cfg_data,
    // item channel
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            command,
    input  logic [pbnc_pkg::IDX_W-1:0]      color_index,
    input  logic [pbnc_pkg::COLOR_W-1:0]    entry_red,
    input  logic [pbnc_pkg::COLOR_W-1:0]    entry_green,
    input  logic [pbnc_pkg::COLOR_W-1:0]    entry_blue,
    input  logic [pbnc_pkg::LEVEL_W-1:0]    shade_level,
    // result channel
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [pbnc_pkg::IDX_W-1:0]      palette_index
);
    import pbnc_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    // Reciprocal for the index wrap; exact for all 8-bit indexes
    localparam int unsigned WRAP_RECIP = (65536 + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES;
    localparam logic [COLOR_W-1:0] LVL_MAX    = COLOR_W'(SHADE_LEVELS - 1);
    localparam logic [AW-1:0]      SCAN_LAST  = AW'(PALETTE_ENTRIES - 1);
    localparam logic [2:0]         BLEND_LAST = 3'd4;
    localparam logic [2:0]         BLEND_FEEDS = 3'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WRAP  = 7'b0000010,
        ST_ADDR  = 7'b0000100,
        ST_BLEND = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [STRENGTH_W-1:0] sheen_strength_reg;
    logic [COLOR_W-1:0]    sheen_red_reg;
    logic [COLOR_W-1:0]    sheen_green_reg;
    logic [COLOR_W-1:0]    sheen_blue_reg;

    // accepted item
    logic               cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    rgb_t               entry_reg;
    logic [LEVEL_W-1:0] level_reg;

    // index wrap and blend setup
    logic [24:0]          wrap_prod;
    logic [IDX_W-1:0]     quot_reg;
    logic [IDX_W:0]       rem;
    logic [AW-1:0]        entry_addr;
    logic [COLOR_W-1:0]   level_sat;
    logic [STRENGTH_W-1:0] strength_sat;
    logic [LS_W-1:0]      ls_reg;

    // blend sequencing
    logic [2:0]         blend_step_reg, blend_step_next;
    mix_req_t           mix_req;
    logic               blend_res_vld;
    logic [COLOR_W-1:0] blend_res;
    rgb_t               target_reg;

    // palette RAM
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [3*COLOR_W-1:0] ram_rd_data;
    rgb_t               ram_color;

    // scan
    logic [AW-1:0]      scan_addr_reg, scan_addr_next;
    scan_tag_t          rd_tag_reg, rd_tag_next;
    logic [IDX_W-1:0]   best_index;
    logic               search_done;

    // result register
    logic               result_valid_reg, result_valid_next;
    logic [IDX_W-1:0]   palette_index_reg;
    logic               result_load;

    // ------------------------------------------------------------------
    // Configuration registers, unguarded: must be written only while the block is idle
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sheen_strength_reg <= STRENGTH_RST;
            sheen_red_reg      <= RED_RST;
            sheen_green_reg    <= GREEN_RST;
            sheen_blue_reg     <= BLUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STRENGTH: sheen_strength_reg <= cfg_data;
                CFG_RED:      sheen_red_reg      <= cfg_data[COLOR_W-1:0];
                CFG_GREEN:    sheen_green_reg    <= cfg_data[COLOR_W-1:0];
                CFG_BLUE:     sheen_blue_reg     <= cfg_data[COLOR_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Index wrap: quotient by reciprocal multiply in WRAP, remainder in ADDR
    // ------------------------------------------------------------------
    assign wrap_prod  = 25'(idx_reg) * 25'(WRAP_RECIP);
    assign rem        = {1'b0, idx_reg} - (IDX_W + 1)'(quot_reg * (IDX_W + 1)'(PALETTE_ENTRIES));
    assign entry_addr = rem[AW-1:0];

    // Saturate level and strength, then form level * strength
    assign level_sat    = (COLOR_W'(level_reg) > LVL_MAX) ? LVL_MAX : COLOR_W'(level_reg);
    assign strength_sat = (sheen_strength_reg > STRENGTH_ONE) ? STRENGTH_ONE
                                                              : sheen_strength_reg;

    // ------------------------------------------------------------------
    // Blend feed: red, green, blue in the first three steps, straight from
    // the RAM read register, which holds the base entry throughout
    // ------------------------------------------------------------------
    assign ram_color = rgb_t'(ram_rd_data);

    always_comb
    begin
        mix_req = '0;
        if ((state_reg == ST_BLEND) && (blend_step_reg < BLEND_FEEDS))
        begin
            mix_req.vld = 1'b1;
            case (blend_step_reg)
                3'd0:
                begin
                    mix_req.base  = ram_color.red;
                    mix_req.sheen = sheen_red_reg;
                end
                3'd1:
                begin
                    mix_req.base  = ram_color.green;
                    mix_req.sheen = sheen_green_reg;
                end
                default:
                begin
                    mix_req.base  = ram_color.blue;
                    mix_req.sheen = sheen_blue_reg;
                end
            endcase
        end
    end

    pbnc_blend #(
        .SHADE_LEVELS (SHADE_LEVELS)
    ) u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mix_req),
        .ls      (ls_reg),
        .res_vld (blend_res_vld),
        .res     (blend_res)
    );

    // ------------------------------------------------------------------
    // Palette RAM: write in ADDR for a write item; read the base entry in
    // ADDR for a query, then every entry in turn during SCAN
    // ------------------------------------------------------------------
    assign ram_wr_en   = (state_reg == ST_ADDR) && (cmd_reg == CMD_WRITE);
    assign ram_rd_en   = ((state_reg == ST_ADDR) && (cmd_reg == CMD_QUERY))
                      || (state_reg == ST_SCAN);
    assign ram_rd_addr = (state_reg == ST_SCAN) ? scan_addr_reg : entry_addr;

    pbnc_ram #(
        .WIDTH (3 * COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (entry_addr),
        .wr_data (entry_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Tag each scan read so the search sees it alongside the read data
    always_comb
    begin
        rd_tag_next = '0;
        if (state_reg == ST_SCAN)
        begin
            rd_tag_next.vld   = 1'b1;
            rd_tag_next.first = (scan_addr_reg == '0);
            rd_tag_next.last  = (scan_addr_reg == SCAN_LAST);
            rd_tag_next.index = IDX_W'(scan_addr_reg);
        end
    end

    pbnc_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .ent_tag    (rd_tag_reg),
        .ent_color  (ram_color),
        .target     (target_reg),
        .best_index (best_index),
        .done       (search_done)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign item_ready  = (state_reg == ST_IDLE);
    assign result_load = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    always_comb
    begin
        state_next      = state_reg;
        blend_step_next = blend_step_reg;
        scan_addr_next  = scan_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                blend_step_next = '0;
                state_next = (cmd_reg == CMD_WRITE) ? ST_IDLE : ST_BLEND;
            end
            ST_BLEND:
            begin
                blend_step_next = blend_step_reg + 3'd1;
                if (blend_step_reg == BLEND_LAST)
                begin
                    scan_addr_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_addr_next = scan_addr_reg + AW'(1);
                if (scan_addr_reg == SCAN_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (search_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            blend_step_reg   <= '0;
            scan_addr_reg    <= '0;
            rd_tag_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            blend_step_reg   <= blend_step_next;
            scan_addr_reg    <= scan_addr_next;
            rd_tag_reg       <= rd_tag_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cmd_reg   <= command;
            idx_reg   <= color_index;
            entry_reg <= '{red: entry_red, green: entry_green, blue: entry_blue};
            level_reg <= shade_level;
        end
        if (state_reg == ST_WRAP)
        begin
            quot_reg <= wrap_prod[23:16];
            ls_reg   <= LS_W'(level_sat * strength_sat);
        end
        // shift blended channels in: red arrives first, blue last
        if (blend_res_vld)
        begin
            target_reg <= '{red: target_reg.green, green: target_reg.blue, blue: blend_res};
        end
        if (result_load)
        begin
            palette_index_reg <= best_index;
        end
    end

    assign result_valid  = result_valid_reg;
    assign palette_index = palette_index_reg;

endmodule

FILE: hdl/pbnc_checker.sv
// Port-level checker for the palette blend and nearest colour block, bound to its top.
// Depends on pbnc_pkg and palette_blend_nearest_color_defines.svh.
`include "palette_blend_nearest_color_defines.svh"

module pbnc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       command,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [pbnc_pkg::IDX_W-1:0] palette_index
);
    import pbnc_pkg::*;

    // a stalled result holds
    `PBNC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(palette_index))

    // a query keeps the block busy once taken
    `PBNC_ASSERT_NEXT(a_query_busy, clk, rst_n, item_valid && item_ready && command == CMD_QUERY, !item_ready)

    // a write keeps the block busy through the index wrap and the RAM write, then frees it
    `PBNC_ASSERT_NEXT(a_write_turn, clk, rst_n, item_valid && item_ready && command == CMD_WRITE, !item_ready ##1 !item_ready ##1 item_ready)

    // a new result only appears at the end of a busy spell
    `PBNC_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(result_valid), $past(!item_ready))

endmodule

bind palette_blend_nearest_color pbnc_checker u_pbnc_checker (.*);

FILE: tb/sv/palette_blend_nearest_color_test.sv
// Self-checking bench for palette_blend_nearest_color: palette writes, shaded queries, sheen setup.
// Depends on pbnc_pkg and the block's RTL; predicts each answer that no row types in from its own palette copy.
module palette_blend_nearest_color_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pbnc_pkg::*;

    localparam int          PAL_N        = PALETTE_ENTRIES_DEF;
    localparam int          LEVELS       = SHADE_LEVELS_DEF;
    localparam int unsigned DENOM        = (LEVELS - 1) * 256;
    localparam int          QUERY_CYCLES = PAL_N + 11;      // one query, from its transfer to its result
    localparam int          DRAIN_CYCLES = 8;               // room for a write's index wrap and RAM write to land
    localparam int          END_CYCLES   = QUERY_CYCLES + 32;
    localparam int          HOLD_AT      = 40;              // result count that triggers the hold-off
    localparam int          HOLD_CYCLES  = 4 * QUERY_CYCLES;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 30;
    localparam int          CYCLE_LIMIT  = 3_500_000;

    // Sheen register mask bits: strength, red, green, blue (register order)
    localparam logic [CFG_IDX_W-1:0] SHEEN_REGS [4] = '{CFG_STRENGTH, CFG_RED, CFG_GREEN, CFG_BLUE};

    typedef enum logic {ROW_ITEM, ROW_SHEEN} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  cmd;
        logic [IDX_W-1:0]      idx;
        rgb_t                  color;      // entry colour, or sheen colour on a sheen row
        logic [LEVEL_W-1:0]    level;
        logic                  known;      // expected index typed in below
        logic [IDX_W-1:0]      answer;
        logic [3:0]            mask;
        logic [STRENGTH_W-1:0] strength;
    } dir_row_t;

    localparam int DIR_N = 25;

    // The palette is filled first with entry i = {i, ~i, i ^ 5A}, so every colour is unique
    // and a level 0 query answers with its own index.
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // identity at reset settings, index extremes
        '{ROW_ITEM,  CMD_QUERY, 8'd0,   24'h000000, 6'd0,  1'b1, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd255, 24'h000000, 6'd0,  1'b1, 8'd255, 4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd77,  24'hFFFFFF, 6'd63, 1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd200, 24'h000000, 6'd31, 1'b0, 8'd0,   4'h0, 9'd0},
        // plant the reset sheen colour, then blend fully onto it
        '{ROW_ITEM,  CMD_WRITE, 8'd17,  24'hCCE6FF, 6'd63, 1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_SHEEN, CMD_WRITE, 8'd0,   24'h000000, 6'd0,  1'b0, 8'd0,   4'b0001, 9'd256},
        '{ROW_ITEM,  CMD_QUERY, 8'd3,   24'h000000, 6'd63, 1'b1, 8'd17,  4'h0, 9'd0},
        // strength beyond one saturates
        '{ROW_SHEEN, CMD_WRITE, 8'd0,   24'h000000, 6'd0,  1'b0, 8'd0,   4'b0001, 9'd511},
        '{ROW_ITEM,  CMD_QUERY, 8'd250, 24'h000000, 6'd63, 1'b1, 8'd17,  4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd9,   24'h000000, 6'd1,  1'b0, 8'd0,   4'h0, 9'd0},
        // zero strength is the identity at any level
        '{ROW_SHEEN, CMD_WRITE, 8'd0,   24'h000000, 6'd0,  1'b0, 8'd0,   4'b0001, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd128, 24'h000000, 6'd63, 1'b1, 8'd128, 4'h0, 9'd0},
        // black sheen at full strength
        '{ROW_SHEEN, CMD_WRITE, 8'd0,   24'h000000, 6'd0,  1'b0, 8'd0,   4'b1111, 9'd256},
        '{ROW_ITEM,  CMD_WRITE, 8'd40,  24'h000000, 6'd0,  1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd255, 24'h000000, 6'd63, 1'b1, 8'd40,  4'h0, 9'd0},
        // white sheen at full strength
        '{ROW_SHEEN, CMD_WRITE, 8'd0,   24'hFFFFFF, 6'd0,  1'b0, 8'd0,   4'b1110, 9'd0},
        '{ROW_ITEM,  CMD_WRITE, 8'd60,  24'hFFFFFF, 6'd0,  1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd0,   24'h000000, 6'd63, 1'b1, 8'd60,  4'h0, 9'd0},
        // duplicate of entry 100: the tie goes to the lower index
        '{ROW_ITEM,  CMD_WRITE, 8'd200, 24'h649B3E, 6'd0,  1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd200, 24'h000000, 6'd0,  1'b1, 8'd100, 4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd100, 24'h000000, 6'd0,  1'b1, 8'd100, 4'h0, 9'd0},
        // mid-range settings, left to the predictor
        '{ROW_SHEEN, CMD_WRITE, 8'd0,   24'h0A80FA, 6'd0,  1'b0, 8'd0,   4'b1111, 9'd128},
        '{ROW_ITEM,  CMD_QUERY, 8'd31,  24'h000000, 6'd32, 1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_QUERY, 8'd222, 24'hFFFFFF, 6'd63, 1'b0, 8'd0,   4'h0, 9'd0},
        '{ROW_ITEM,  CMD_WRITE, 8'd5,   24'hFFFFFF, 6'd63, 1'b0, 8'd0,   4'h0, 9'd0}
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_STRENGTH;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic                  command      = CMD_WRITE;
    logic [IDX_W-1:0]      color_index  = '0;
    logic [COLOR_W-1:0]    entry_red    = '0;
    logic [COLOR_W-1:0]    entry_green  = '0;
    logic [COLOR_W-1:0]    entry_blue   = '0;
    logic [LEVEL_W-1:0]    shade_level  = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [IDX_W-1:0]      palette_index;

    // Bench copy of the block's state
    rgb_t                  palette_copy [PAL_N];
    logic [STRENGTH_W-1:0] sheen_str;
    rgb_t                  sheen_rgb;

    logic [IDX_W-1:0]      nearest_q [$];   // expected answers, oldest first
    int                    mismatches   = 0;
    int                    results_seen = 0;
    bit                    sender_calm  = 1'b0;

    palette_blend_nearest_color u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .command       (command),
        .color_index   (color_index),
        .entry_red     (entry_red),
        .entry_green   (entry_green),
        .entry_blue    (entry_blue),
        .shade_level   (shade_level),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .palette_index (palette_index)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Blend one channel towards the sheen, rounding half up, in exact integers.
    function automatic logic [COLOR_W-1:0] blend_toward(logic [COLOR_W-1:0] p,
                                                         logic [COLOR_W-1:0] s,
                                                         int unsigned ls);
        longint unsigned num;
        num = 2 * (longint'(p) * (DENOM - ls) + longint'(s) * ls) + DENOM;
        return COLOR_W'(num / (2 * DENOM));
    endfunction

    // Shade the base entry, then scan the palette copy for the closest colour.
    function automatic logic [IDX_W-1:0] shade_and_match(logic [IDX_W-1:0] base_idx,
                                                          logic [LEVEL_W-1:0] level);
        int unsigned      str;
        int unsigned      lvl;
        int unsigned      ls;
        rgb_t             base;
        rgb_t             tint;
        int               dr;
        int               dg;
        int               db;
        int unsigned      sq_dist;
        int unsigned      best_dist;
        logic [IDX_W-1:0] best;
        int               i;
        str  = (sheen_str > STRENGTH_ONE) ? STRENGTH_ONE : sheen_str;
        lvl  = (level > LEVELS - 1) ? LEVELS - 1 : level;
        ls   = lvl * str;
        base = palette_copy[base_idx % PAL_N];
        tint.red   = blend_toward(base.red,   sheen_rgb.red,   ls);
        tint.green = blend_toward(base.green, sheen_rgb.green, ls);
        tint.blue  = blend_toward(base.blue,  sheen_rgb.blue,  ls);
        best      = '0;
        best_dist = 32'hFFFF_FFFF;
        for (i = 0; i < PAL_N; i++)
        begin
            dr   = int'(palette_copy[i].red)   - int'(tint.red);
            dg   = int'(palette_copy[i].green) - int'(tint.green);
            db   = int'(palette_copy[i].blue)  - int'(tint.blue);
            sq_dist = dr * dr + dg * dg + db * db;
            // strict compare keeps the lowest index on a tie
            if (sq_dist < best_dist)
            begin
                best_dist = sq_dist;
                best      = IDX_W'(i);
            end
        end
        return best;
    endfunction

    // Mostly short idles, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 16);
        return $urandom_range(40, 400);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_channel();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
        mismatches++;
        $display("[%0t] mismatch: %s, palette_index got %0d want %0d", $time, what, got, want);
    endtask

    // Drop valid and hold until every answer is back and a write has had time to land.
    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the sheen registers picked by mask, back to back, once the block is idle.
    task automatic program_sheen(logic [3:0] mask, logic [STRENGTH_W-1:0] str, rgb_t tint);
        int                    k;
        logic [CFG_DATA_W-1:0] value;
        wait_quiet();
        for (k = 0; k < 4; k++)
        begin
            if (mask[k])
            begin
                case (SHEEN_REGS[k])
                    CFG_STRENGTH: begin value = str;        sheen_str       = str;        end
                    CFG_RED:      begin value = tint.red;   sheen_rgb.red   = tint.red;   end
                    CFG_GREEN:    begin value = tint.green; sheen_rgb.green = tint.green; end
                    default:      begin value = tint.blue;  sheen_rgb.blue  = tint.blue;  end
                endcase
                cfg_we    <= 1'b1;
                cfg_index <= SHEEN_REGS[k];
                cfg_data  <= value;
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    // Offer one item and hold it until the transfer; valid stays high afterwards so that a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic offer_item(logic cmd, logic [IDX_W-1:0] idx, rgb_t color,
                              logic [LEVEL_W-1:0] level, logic known,
                              logic [IDX_W-1:0] answer);
        int gap;
        gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        color_index <= idx;
        entry_red   <= color.red;
        entry_green <= color.green;
        entry_blue  <= color.blue;
        shade_level <= level;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // transfer taken at this edge: advance the bench copy
        if (cmd == CMD_WRITE)
            palette_copy[idx % PAL_N] = color;
        else
            nearest_q.push_back(known ? answer : shade_and_match(idx, level));
    endtask

    // Result side: check each transfer against the oldest expectation, stall at random,
    // and once hold ready low long enough for the block to back up onto its input.
    initial
    begin : result_side
        int               stall_left;
        int               hold_left;
        bit               calm;
        logic [IDX_W-1:0] want;
        stall_left = 0;
        hold_left  = 0;
        calm       = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (nearest_q.size() == 0)
                    flag_mismatch("result with nothing outstanding", palette_index, '0);
                else
                begin
                    want = nearest_q.pop_front();
                    if (palette_index !== want)
                        flag_mismatch("nearest entry", palette_index, want);
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 1999) == 0)
                calm = !calm;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                stall_left = idle_len() - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog: give up well beyond the slowest legal run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL palette_blend_nearest_color");
        $finish;
    end

    initial
    begin : stimulus
        int               n;
        int               ph;
        int               k;
        int               pick;
        rgb_t             color;
        rgb_t             tint;
        logic [IDX_W-1:0] idx;
        logic [LEVEL_W-1:0] level;
        logic [STRENGTH_W-1:0] str;
        logic [3:0]       mask;

        for (n = 0; n < PAL_N; n++)
            palette_copy[n] = '0;
        sheen_str = STRENGTH_RST;
        sheen_rgb = '{RED_RST, GREEN_RST, BLUE_RST};

        // hold reset, then release it on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every entry before the first query: unwritten entries read as undefined.
        for (n = 0; n < PAL_N; n++)
        begin
            color = '{COLOR_W'(n), ~COLOR_W'(n), COLOR_W'(n) ^ 8'h5A};
            offer_item(CMD_WRITE, IDX_W'(n), color, LEVEL_W'($urandom_range(0, 63)), 1'b0, '0);
        end

        // Directed rows
        for (n = 0; n < DIR_N; n++)
        begin
            if (DIR_ROWS[n].kind == ROW_SHEEN)
                program_sheen(DIR_ROWS[n].mask, DIR_ROWS[n].strength, DIR_ROWS[n].color);
            else
                offer_item(DIR_ROWS[n].cmd, DIR_ROWS[n].idx, DIR_ROWS[n].color,
                           DIR_ROWS[n].level, DIR_ROWS[n].known, DIR_ROWS[n].answer);
        end

        // Random phases, each behind a fresh sheen setting; extremes come up often.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 4))
                0:       str = '0;
                1:       str = STRENGTH_ONE;
                2:       str = '1;
                default: str = STRENGTH_W'($urandom_range(0, 511));
            endcase
            tint = '{pick_channel(), pick_channel(), pick_channel()};
            mask = (ph == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
            program_sheen(mask, str, tint);
            sender_calm = (ph == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                pick  = $urandom_range(0, 99);
                idx   = IDX_W'($urandom_range(0, 255));
                level = LEVEL_W'($urandom_range(0, 63));
                color = '{COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                          COLOR_W'($urandom_range(0, 255))};
                if (pick < 30)
                    offer_item(CMD_WRITE, idx, color, level, 1'b0, '0);
                else if (pick < 40)
                    // copy another entry's colour to set up ties
                    offer_item(CMD_WRITE, idx, palette_copy[$urandom_range(0, PAL_N - 1)],
                               level, 1'b0, '0);
                else
                begin
                    if (pick < 46)
                        level = '0;
                    else if (pick < 52)
                        level = '1;
                    offer_item(CMD_QUERY, idx, color, level, 1'b0, '0);
                end
            end
        end
        sender_calm = 1'b0;

        // drain, then leave room for any stray result
        item_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS palette_blend_nearest_color");
        else
            $display("FAIL palette_blend_nearest_color");
        $finish;
    end

endmodule
